/* rtl/mu8s_pkg.sv */
// shared types and constants of the modified utf-8 sanitizer
// no dependencies
`timescale 1ns / 1ps

package mu8s_pkg;

  // most result beats one input beat can cause
  localparam int MaxOut = 10;
  localparam int CntW   = $clog2(MaxOut + 1);

  // replacement character U+FFFD in utf-8
  localparam logic [7:0] Fffd0 = 8'hEF;
  localparam logic [7:0] Fffd1 = 8'hBF;
  localparam logic [7:0] Fffd2 = 8'hBD;

  typedef logic [MaxOut-1:0][7:0] byte_list_t;

  // all result beats of one input beat, handed from decoder to emitter
  typedef struct packed {
    byte_list_t      bytes;     // entry 0 goes out first
    logic [CntW-1:0] cnt;       // number of result beats, 0 = none
    logic            data;      // 0 only for a bare end marker
    logic            done;      // input beat was an end marker
  } burst_t;

endpackage

/* rtl/mu8s_in_if.sv */
// input channel of the sanitizer: one source byte or an end marker per beat
// depends on nothing
`timescale 1ns / 1ps

interface mu8s_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_end;

  modport source (output valid, output in_byte, output is_end, input ready);
  modport sink   (input valid, input in_byte, input is_end, output ready);
endinterface

/* rtl/mu8s_out_if.sv */
// result channel of the sanitizer: one modified utf-8 byte per beat
// depends on nothing
`timescale 1ns / 1ps

interface mu8s_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last_in_run;
  logic       string_done;

  modport source (output valid, output out_byte, output byte_valid,
                  output last_in_run, output string_done, input ready);
  modport sink   (input valid, input out_byte, input byte_valid,
                  input last_in_run, input string_done, output ready);
endinterface

/* rtl/mu8s_decode.sv */
// sequence state and per-beat decode into a list of result bytes
// depends on mu8s_pkg
`timescale 1ns / 1ps

module mu8s_decode (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      in_byte,
  input  logic            is_end,
  output mu8s_pkg::burst_t burst
);
  import mu8s_pkg::*;

  localparam logic [15:0] SurLo   = 16'hD800;
  localparam logic [15:0] SurHi   = 16'hDFFF;
  localparam logic [15:0] LowSurr = 16'hDC00;
  localparam logic [15:0] Min3    = 16'h0800;
  localparam logic [20:0] Min4    = 21'h10000;
  localparam logic [20:0] Max4    = 21'h10FFFF;
  localparam logic [9:0]  Mask10  = 10'h3FF;

  logic [7:0]      lead_r, lead_nxt;
  logic [1:0][5:0] cont_r, cont_nxt;
  logic [1:0]      pend_r, pend_nxt;
  logic [1:0]      seq_r, seq_nxt;

  // start of a new sequence
  logic [2:0][7:0] st_bytes;
  logic [1:0]      st_n;
  logic [1:0]      st_seq;

  always_comb begin
    st_bytes = '0;
    st_n     = 2'd0;
    st_seq   = 2'd0;
    if (in_byte == 8'h00) begin
      st_bytes[0] = 8'hC0;
      st_bytes[1] = 8'h80;
      st_n        = 2'd2;
    end else if (!in_byte[7]) begin
      st_bytes[0] = in_byte;
      st_n        = 2'd1;
    end else if (in_byte[7:5] == 3'b110) begin
      st_seq = 2'd1;
    end else if (in_byte[7:4] == 4'b1110) begin
      st_seq = 2'd2;
    end else if (in_byte[7:3] == 5'b11110) begin
      st_seq = 2'd3;
    end else begin
      st_bytes = {Fffd2, Fffd1, Fffd0};
      st_n     = 2'd3;
    end
  end

  // completion of a pending sequence by its final continuation byte
  logic [15:0]     cp3;
  logic [20:0]     cp4, v4;
  logic [15:0]     hi, lo;
  logic [5:0][7:0] cm_bytes;
  logic [2:0]      cm_n;

  always_comb begin
    cp3 = {lead_r[3:0], cont_r[0], in_byte[5:0]};
    cp4 = {lead_r[2:0], cont_r[0], cont_r[1], in_byte[5:0]};
    v4  = cp4 - Min4;
    hi  = SurLo + {6'd0, v4[19:10]};
    lo  = LowSurr + {6'd0, v4[9:0] & Mask10};
    cm_bytes = '0;
    cm_bytes[2:0] = {Fffd2, Fffd1, Fffd0};
    cm_n = 3'd3;
    unique case (seq_r)
      2'd1: begin
        if (lead_r[4:1] != 4'd0) begin
          cm_bytes[0] = lead_r;
          cm_bytes[1] = {2'b10, in_byte[5:0]};
          cm_bytes[2] = '0;
          cm_n        = 3'd2;
        end
      end
      2'd2: begin
        if (cp3 >= Min3 && !(cp3 >= SurLo && cp3 <= SurHi)) begin
          cm_bytes[0] = lead_r;
          cm_bytes[1] = {2'b10, cont_r[0]};
          cm_bytes[2] = {2'b10, in_byte[5:0]};
        end
      end
      2'd3: begin
        if (cp4 >= Min4 && cp4 <= Max4) begin
          cm_bytes[0] = 8'hE0 | {4'd0, hi[15:12]};
          cm_bytes[1] = 8'h80 | {2'd0, hi[11:6]};
          cm_bytes[2] = 8'h80 | {2'd0, hi[5:0]};
          cm_bytes[3] = 8'hE0 | {4'd0, lo[15:12]};
          cm_bytes[4] = 8'h80 | {2'd0, lo[11:6]};
          cm_bytes[5] = 8'h80 | {2'd0, lo[5:0]};
          cm_n        = 3'd6;
        end
      end
      default: begin
      end
    endcase
  end

  // choose the prefix of replacement characters and the tail bytes
  logic [1:0]      nf;
  logic [5:0][7:0] sfx;
  logic [2:0]      sfx_n;
  logic            merge;

  always_comb begin
    nf       = 2'd0;
    sfx      = '0;
    sfx_n    = 3'd0;
    merge    = 1'b0;
    lead_nxt = lead_r;
    cont_nxt = cont_r;
    pend_nxt = pend_r;
    seq_nxt  = seq_r;
    if (is_end) begin
      if (seq_r != 2'd0) begin
        nf = 2'd1 + pend_r;
      end
      lead_nxt = '0;
      cont_nxt = '0;
      pend_nxt = '0;
      seq_nxt  = '0;
    end else if (seq_r == 2'd0) begin
      sfx[2:0] = st_bytes;
      sfx_n    = {1'b0, st_n};
      lead_nxt = (st_seq != 2'd0) ? in_byte : 8'h00;
      cont_nxt = '0;
      pend_nxt = '0;
      seq_nxt  = st_seq;
    end else if (in_byte[7:6] == 2'b10) begin
      if (({1'b0, pend_r} + 3'd1) < {1'b0, seq_r} && pend_r < 2'd2) begin
        cont_nxt[pend_r[0]] = in_byte[5:0];
        pend_nxt            = pend_r + 2'd1;
      end else begin
        sfx      = cm_bytes;
        sfx_n    = cm_n;
        lead_nxt = '0;
        cont_nxt = '0;
        pend_nxt = '0;
        seq_nxt  = '0;
      end
    end else begin
      // broken sequence, then rescan the breaking byte
      merge    = (seq_r == 2'd3) && (in_byte == 8'h00 || in_byte >= 8'hF8);
      nf       = (merge && pend_r == 2'd2) ? 2'd2 : 2'd1 + pend_r;
      sfx[2:0] = st_bytes;
      sfx_n    = {1'b0, st_n};
      lead_nxt = (st_seq != 2'd0) ? in_byte : 8'h00;
      cont_nxt = '0;
      pend_nxt = '0;
      seq_nxt  = st_seq;
    end
  end

  // assemble the list, capped at MaxOut entries
  logic [3:0]      pre_len;
  logic [4:0]      total;
  logic [3:0]      j;
  logic [2:0][7:0] fffd;

  always_comb begin
    fffd    = {Fffd2, Fffd1, Fffd0};
    pre_len = {2'd0, nf} + {1'b0, nf, 1'b0};
    total   = {1'b0, pre_len} + {2'd0, sfx_n};
    burst   = '0;
    j       = '0;
    for (int k = 0; k < MaxOut; k++) begin
      if (4'(k) < pre_len) begin
        burst.bytes[k] = fffd[k % 3];
      end else begin
        j = 4'(k) - pre_len;
        if (j < {1'b0, sfx_n}) begin
          burst.bytes[k] = sfx[j[2:0]];
        end
      end
    end
    burst.cnt  = (total > 5'(MaxOut)) ? CntW'(MaxOut) : CntW'(total);
    burst.data = 1'b1;
    burst.done = is_end;
    if (is_end && total == 5'd0) begin
      burst.cnt  = CntW'(1);
      burst.data = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r <= '0;
      cont_r <= '0;
      pend_r <= '0;
      seq_r  <= '0;
    end else if (accept) begin
      lead_r <= lead_nxt;
      cont_r <= cont_nxt;
      pend_r <= pend_nxt;
      seq_r  <= seq_nxt;
    end
  end

endmodule

/* rtl/mu8s_emit.sv */
// result buffer: holds one decoded list and sends it one byte per beat
// depends on mu8s_pkg and mu8s_out_if
`timescale 1ns / 1ps

module mu8s_emit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  mu8s_pkg::burst_t burst,
  output logic             can_load,
  mu8s_out_if.source       out_ch
);
  import mu8s_pkg::*;

  byte_list_t      buf_r, buf_nxt;
  logic [CntW-1:0] rem_r, rem_nxt;
  logic            data_r, data_nxt;
  logic            done_r, done_nxt;
  logic            take;

  assign take     = out_ch.valid && out_ch.ready;
  // free now, or the last byte leaves this cycle
  assign can_load = (rem_r == '0) || (rem_r == CntW'(1) && out_ch.ready);

  always_comb begin
    buf_nxt  = buf_r;
    rem_nxt  = rem_r;
    data_nxt = data_r;
    done_nxt = done_r;
    if (load && burst.cnt != '0) begin
      buf_nxt  = burst.bytes;
      rem_nxt  = burst.cnt;
      data_nxt = burst.data;
      done_nxt = burst.done;
    end else if (take) begin
      buf_nxt  = buf_r >> 8;
      rem_nxt  = rem_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r  <= buf_nxt;
    data_r <= data_nxt;
    done_r <= done_nxt;
  end

  assign out_ch.valid       = (rem_r != '0);
  assign out_ch.out_byte    = buf_r[0];
  assign out_ch.byte_valid  = data_r;
  assign out_ch.last_in_run = (rem_r == CntW'(1));
  assign out_ch.string_done = done_r && (rem_r == CntW'(1));

endmodule

/* rtl/utf8_to_modified_utf8_sanitizer_unit.sv */
// top level of the utf-8 to modified utf-8 sanitizer
// depends on mu8s_pkg, mu8s_in_if, mu8s_out_if, mu8s_decode, mu8s_emit
`timescale 1ns / 1ps

// channel  | dir | payload                                       | beat
// ---------+-----+-----------------------------------------------+-------------------------
// in_ch    | in  | in_byte[7:0], is_end                          | one source byte or end
// out_ch   | out | out_byte[7:0], byte_valid, last_in_run,       | one modified utf-8 byte
//          |     | string_done                                   |
//
// an input beat is decoded in the cycle it is accepted and its whole result list
// (0 to 10 bytes) lands in the result buffer at that edge
// the buffer sends one byte per cycle while out_ch is ready, so a beat that causes
// n bytes holds in_ch until its last byte leaves; the single read port sets this
// in_ch is ready when the buffer is empty or its last byte is taken this cycle, so
// beats that cause nothing or one byte flow at one per cycle while out_ch is ready
// rst_n is synchronous: it clears the pending sequence and empties the buffer
// a stall on out_ch holds the buffer and backs up into in_ch; nothing is dropped

module utf8_to_modified_utf8_sanitizer_unit (
  input  logic       clk,
  input  logic       rst_n,
  mu8s_in_if.sink    in_ch,
  mu8s_out_if.source out_ch
);
  import mu8s_pkg::*;

  burst_t burst;
  logic   can_load;
  logic   accept;

  // an item is taken whenever the result buffer can swallow its list
  assign in_ch.ready = can_load;
  assign accept      = in_ch.valid && can_load;

  // sequence tracking and decode of the current beat
  mu8s_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_ch.in_byte),
    .is_end  (in_ch.is_end),
    .burst   (burst)
  );

  // result buffer and byte serializer
  mu8s_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept),
    .burst    (burst),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule
